/* sv/isrs_pkg.sv */
// Package for the sensor register slave: payload words, event codes, bus modes and map helpers.
package isrs_pkg;

	// event codes carried in the kind field
	typedef enum logic [2:0] {
		EV_START   = 3'd0,
		EV_STOP    = 3'd1,
		EV_RX_BYTE = 3'd2,
		EV_TX_REQ  = 3'd3,
		EV_CONSOLE = 3'd4
	} event_kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_TEMP_HIGH   = 3'd0,
		CFG_TEMP_LOW    = 3'd1,
		CFG_CMD_STATUS  = 3'd2,
		CFG_SYS_CONFIG  = 3'd3,
		CFG_PRESS_CONFIG = 3'd4
	} cfg_index_t;

	localparam int unsigned NUM_CFG = 5;
	localparam int unsigned CFG_W = 8;

	// bus mode, one-hot
	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_ADDR = 4'b0010,
		MODE_TX   = 4'b0100,
		MODE_RX   = 4'b1000
	} bus_mode_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} in_word_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
	} out_word_t;

	typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;

	localparam logic [7:0]  CFG_RESET [NUM_CFG] = '{8'd24, 8'd228, 8'd2, 8'd17, 8'd32};
	localparam logic [23:0] PRESSURE_RESET = 24'h61A800;
	localparam logic [10:0] PRESSURE_STEP  = 11'd1250;
	localparam logic [2:0]  LAST_POSITION  = 3'd7;
	localparam logic [2:0]  FIRST_CFG_POS  = 3'd3;
	localparam logic [7:0]  RX_READ_BYTE   = 8'hFF;
	localparam logic [7:0]  CHAR_ZERO      = 8'h30;
	localparam logic [7:0]  CHAR_NINE      = 8'h39;

	// sparse register address to map position; unknown gives position 0
	function automatic logic [2:0] position_of(input logic [7:0] addr);
		logic [2:0] pos;
		case (addr)
			8'h06:   pos = 3'd0;
			8'h07:   pos = 3'd1;
			8'h08:   pos = 3'd2;
			8'h09:   pos = 3'd3;
			8'h0A:   pos = 3'd4;
			8'h30:   pos = 3'd5;
			8'hA5:   pos = 3'd6;
			8'hA6:   pos = 3'd7;
			default: pos = 3'd0;
		endcase
		return pos;
	endfunction

endpackage

/* sv/isrs_core.sv */
// Bus mode machine, register pointer, pressure value and byte select for one event.
module isrs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  isrs_pkg::in_word_t  word,
	input  isrs_pkg::cfg_regs_t cfg,
	output isrs_pkg::out_word_t result
);
	import isrs_pkg::*;

	bus_mode_t   mode_q, mode_d;
	logic [7:0]  addr_q, addr_d;
	logic [2:0]  pos_q, pos_d;
	logic [23:0] pressure_q, pressure_d;

	logic [2:0]  rd_pos;
	logic [2:0]  cfg_sel;
	logic [7:0]  map_byte;
	logic [3:0]  digit;
	logic [13:0] scaled;

	// pointer for this read: fresh lookup unless already transmitting
	assign rd_pos  = (mode_q == MODE_TX) ? pos_q : position_of(addr_q);
	assign cfg_sel = rd_pos - FIRST_CFG_POS;

	// map byte select
	always_comb begin
		case (rd_pos)
			3'd0:    map_byte = pressure_q[23:16];
			3'd1:    map_byte = pressure_q[15:8];
			3'd2:    map_byte = pressure_q[7:0];
			default: map_byte = cfg[cfg_sel];
		endcase
	end

	// console digit scaling; product stays below 2^14
	assign digit  = 4'(word.data - CHAR_ZERO);
	assign scaled = 14'(digit) * 14'(PRESSURE_STEP);

	// next state and result
	always_comb begin
		mode_d     = mode_q;
		addr_d     = addr_q;
		pos_d      = pos_q;
		pressure_d = pressure_q;
		result     = '0;
		case (word.kind)
			EV_START: begin
				mode_d = MODE_IDLE;
			end
			EV_STOP: begin
				// stop right after the address keeps it for a repeated read
				if (mode_q != MODE_ADDR) begin
					mode_d = MODE_IDLE;
				end
			end
			EV_RX_BYTE: begin
				if (mode_q == MODE_IDLE) begin
					mode_d = MODE_ADDR;
					addr_d = word.data;
				end else if (mode_q == MODE_ADDR) begin
					mode_d = MODE_RX;
				end
			end
			EV_TX_REQ: begin
				result.tx_valid = 1'b1;
				if (mode_q == MODE_RX) begin
					result.tx_byte = RX_READ_BYTE;
				end else begin
					mode_d         = MODE_TX;
					result.tx_byte = map_byte;
					pos_d          = (rd_pos < LAST_POSITION) ? rd_pos + 3'd1 : rd_pos;
				end
			end
			EV_CONSOLE: begin
				if (word.data inside {[CHAR_ZERO:CHAR_NINE]}) begin
					pressure_d = {2'b00, scaled, 8'h00};
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			addr_q     <= '0;
			pos_q      <= '0;
			pressure_q <= PRESSURE_RESET;
		end else if (step) begin
			mode_q     <= mode_d;
			addr_q     <= addr_d;
			pos_q      <= pos_d;
			pressure_q <= pressure_d;
		end
	end

endmodule

/* sv/i2c_sensor_register_slave_top.sv */
// Top level of the byte-level sensor register slave: input stage, config registers, output stage.
//
//   channel | signals                        | word
//   in      | in_valid, in_stall, in_word    | kind, data
//   out     | out_valid, out_stall, out_word | tx_byte, tx_valid
//   cfg     | cfg_we, cfg_index, cfg_data    | one 8-bit register per write
//
// One event per cycle while in_stall is low; a taken word sits in the input register and
// its result is registered into out_word when the output advances (mode and pointer logic in between).
// Reset puts mode idle, address and pointer at 0, pressure and config at their defaults.
// While the output is stalled, one more word is taken into the input register,
// then in_stall rises until the output word is taken.
module i2c_sensor_register_slave_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  isrs_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output isrs_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import isrs_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	logic      advance;
	cfg_regs_t cfg_q;
	out_word_t result;

	// stage 1 moves on when the output register is free or being emptied
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// config registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we && (cfg_index < 3'(NUM_CFG))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	isrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.word   (word_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_word <= result;
		end
	end

endmodule

/* sv/isrs_checker.sv */
// Port-level checks for the sensor register slave, bound to the top level.
module isrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input isrs_pkg::out_word_t out_word
);
	import isrs_pkg::*;

	// a held output word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// input only backs up behind a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	// non-transmit words carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.tx_valid |-> out_word.tx_byte == 8'h00)
		else $error("nonzero byte on a non-transmit word");

	// an offered word in front of an empty output slot is taken
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

endmodule

bind i2c_sensor_register_slave_top isrs_checker u_isrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
